// File: src/bitplane_delta_frame_decoder_assert.svh
// Assertion macros used by the decoder's command queue.
`ifndef BITPLANE_DELTA_FRAME_DECODER_ASSERT_SVH
`define BITPLANE_DELTA_FRAME_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BDFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bdfd_pkg.sv
// Types, constants and helper functions for the bitplane delta frame decoder.
package bdfd_pkg;

    localparam int ROW_GROUPS   = 40;
    localparam int ROWS         = 200;
    localparam int PLANE_GROUPS = ROW_GROUPS * ROWS;
    localparam int NUM_PLANES   = 4;

    localparam int ADDR_W = $clog2(PLANE_GROUPS);
    localparam int WG_W   = $clog2(PLANE_GROUPS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int RS_W   = ROW_W + 7;
    localparam int LIN_W  = $clog2(PLANE_GROUPS + 128) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CODE_END = 8'h81;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_DELTA = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CODE = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_READ   = 2'd1,
        RES_FINISH = 2'd2
    } t_res;

    typedef struct packed {
        logic              wr_en;
        logic [1:0]        plane;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        t_res              res;
        logic              oor;
        logic              marker;
        logic              clip;
    } t_cmd;

    // Planar to chunky: pixel k takes bit 7-k of each plane, plane p in bit p.
    function automatic logic [31:0] f_chunky(input logic [NUM_PLANES-1:0][7:0] planes);
        logic [31:0] pix;
        pix = '0;
        for (int k = 0; k < 8; k++) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                pix[4*k + p] = planes[p][7-k];
            end
        end
        return pix;
    endfunction

endpackage

// File: src/bdfd_in_if.sv
// Input channel: frame bytes and read requests.
interface bdfd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        first_byte;
    logic [7:0]  data_byte;
    logic [12:0] read_group;

    modport source(output valid, output req_type, output first_byte, output data_byte,
                   output read_group, input ready);
    modport sink(input valid, input req_type, input first_byte, input data_byte,
                 input read_group, output ready);
endinterface

// File: src/bdfd_out_if.sv
// Output channel: pixel reads and frame-finished reports.
interface bdfd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] pixels;
    logic        ended_by_marker;
    logic        clipped;

    modport source(output valid, output result_kind, output pixels,
                   output ended_by_marker, output clipped, input ready);
    modport sink(input valid, input result_kind, input pixels,
                 input ended_by_marker, input clipped, output ready);
endinterface

// File: src/bdfd_front.sv
// Front end: accepts beats, runs the key/delta parser and issues store commands.
module bdfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bdfd_in_if.sink             i_in,
    input  logic                i_cmd_ready,
    output logic                o_cmd_valid,
    output bdfd_pkg::t_cmd      o_cmd
);

    bdfd_pkg::t_phase                    r_phase, n_phase;
    logic [1:0]                          r_plane, n_plane;
    logic [bdfd_pkg::ROW_W-1:0]          r_row, n_row;
    logic [6:0]                          r_col, n_col;
    logic [bdfd_pkg::WG_W-1:0]           r_wg, n_wg;
    logic [7:0]                          r_bl, n_bl;
    logic [1:0]                          r_key_plane, n_key_plane;
    logic [bdfd_pkg::ADDR_W-1:0]         r_key_group, n_key_group;
    logic                                r_key_done, n_key_done;
    logic                                r_clip, n_clip;

    logic accept;

    assign i_in.ready = i_cmd_ready;
    assign accept     = i_in.valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bdfd_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_wg        <= '0;
            r_bl        <= '0;
            r_key_plane <= '0;
            r_key_group <= '0;
            r_key_done  <= 1'b0;
            r_clip      <= 1'b0;
        end else begin
            r_plane     <= n_plane;
            r_row       <= n_row;
            r_col       <= n_col;
            r_wg        <= n_wg;
            r_bl        <= n_bl;
            r_key_plane <= n_key_plane;
            r_key_group <= n_key_group;
            r_key_done  <= n_key_done;
            r_clip      <= n_clip;
        end
    end

    always_comb begin
        logic [8:0]                   acc;
        logic [bdfd_pkg::RS_W-1:0]    row_sum;
        logic [bdfd_pkg::LIN_W-1:0]   lin;
        logic [7:0]                   b;
        logic                         first;
        bdfd_pkg::t_phase             ph;

        n_phase     = r_phase;
        n_plane     = r_plane;
        n_row       = r_row;
        n_col       = r_col;
        n_wg        = r_wg;
        n_bl        = r_bl;
        n_key_plane = r_key_plane;
        n_key_group = r_key_group;
        n_key_done  = r_key_done;
        n_clip      = r_clip;

        o_cmd_valid  = 1'b0;
        o_cmd.wr_en  = 1'b0;
        o_cmd.plane  = '0;
        o_cmd.addr   = '0;
        o_cmd.data   = i_in.data_byte;
        o_cmd.res    = bdfd_pkg::RES_NONE;
        o_cmd.oor    = 1'b0;
        o_cmd.marker = 1'b0;
        o_cmd.clip   = 1'b0;

        b       = i_in.data_byte;
        first   = i_in.first_byte;
        ph      = r_phase;
        acc     = '0;
        row_sum = '0;
        lin     = '0;

        if (accept) begin
            case (bdfd_pkg::t_req'(i_in.req_type))
                bdfd_pkg::REQ_KEY: begin
                    if (first) begin
                        n_key_plane = '0;
                        n_key_group = '0;
                        n_key_done  = 1'b0;
                        n_clip      = 1'b0;
                        n_phase     = bdfd_pkg::PH_IDLE;
                    end
                    if (!n_key_done) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.wr_en = 1'b1;
                        o_cmd.plane = n_key_plane;
                        o_cmd.addr  = n_key_group;
                        if (n_key_group == bdfd_pkg::ADDR_W'(bdfd_pkg::PLANE_GROUPS - 1)) begin
                            n_key_group = '0;
                            if (n_key_plane == 2'd3) begin
                                n_key_done   = 1'b1;
                                o_cmd.res    = bdfd_pkg::RES_FINISH;
                                o_cmd.clip   = n_clip;
                            end
                            n_key_plane = n_key_plane + 2'd1;
                        end else begin
                            n_key_group = n_key_group + 1'b1;
                        end
                    end
                end
                bdfd_pkg::REQ_DELTA: begin
                    if (first) begin
                        n_plane = '0;
                        n_row   = '0;
                        n_wg    = '0;
                        n_bl    = '0;
                        n_clip  = 1'b0;
                        ph      = bdfd_pkg::PH_CODE;
                        n_phase = bdfd_pkg::PH_CODE;
                    end
                    case (ph)
                        bdfd_pkg::PH_CODE: begin
                            if (b == bdfd_pkg::CODE_END) begin
                                n_phase      = bdfd_pkg::PH_IDLE;
                                o_cmd_valid  = 1'b1;
                                o_cmd.res    = bdfd_pkg::RES_FINISH;
                                o_cmd.marker = 1'b1;
                                o_cmd.clip   = n_clip;
                            end else if (b[7]) begin
                                // Cursor step: plane in the low two bits, carries into the row.
                                acc     = 9'(n_plane) + (9'd256 - 9'(b));
                                row_sum = bdfd_pkg::RS_W'(n_row) + bdfd_pkg::RS_W'(acc[8:2]);
                                n_plane = acc[1:0];
                                if (row_sum >= bdfd_pkg::RS_W'(bdfd_pkg::ROWS)) begin
                                    n_row        = bdfd_pkg::ROW_W'(bdfd_pkg::ROWS);
                                    n_phase      = bdfd_pkg::PH_IDLE;
                                    o_cmd_valid  = 1'b1;
                                    o_cmd.res    = bdfd_pkg::RES_FINISH;
                                    o_cmd.clip   = n_clip;
                                end else begin
                                    n_row = bdfd_pkg::ROW_W'(row_sum);
                                end
                            end else begin
                                n_col   = b[6:0];
                                n_phase = bdfd_pkg::PH_LEN;
                            end
                        end
                        bdfd_pkg::PH_LEN: begin
                            lin = bdfd_pkg::LIN_W'(n_row) * bdfd_pkg::LIN_W'(bdfd_pkg::ROW_GROUPS)
                                + bdfd_pkg::LIN_W'(n_col);
                            if (lin > bdfd_pkg::LIN_W'(bdfd_pkg::PLANE_GROUPS)) begin
                                n_wg = bdfd_pkg::WG_W'(bdfd_pkg::PLANE_GROUPS);
                            end else begin
                                n_wg = bdfd_pkg::WG_W'(lin);
                            end
                            n_bl    = b;
                            n_phase = (b == 8'd0) ? bdfd_pkg::PH_CODE : bdfd_pkg::PH_DATA;
                        end
                        bdfd_pkg::PH_DATA: begin
                            if (n_wg < bdfd_pkg::WG_W'(bdfd_pkg::PLANE_GROUPS)) begin
                                o_cmd_valid = 1'b1;
                                o_cmd.wr_en = 1'b1;
                                o_cmd.plane = n_plane;
                                o_cmd.addr  = bdfd_pkg::ADDR_W'(n_wg);
                                n_wg        = n_wg + 1'b1;
                            end else begin
                                n_clip = 1'b1;
                            end
                            n_bl = n_bl - 8'd1;
                            if (n_bl == 8'd0) begin
                                n_phase = bdfd_pkg::PH_CODE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                bdfd_pkg::REQ_READ: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.res   = bdfd_pkg::RES_READ;
                    o_cmd.addr  = bdfd_pkg::ADDR_W'(i_in.read_group);
                    o_cmd.oor   = (32'(i_in.read_group) >= bdfd_pkg::PLANE_GROUPS);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/bdfd_queue.sv
// Short command queue between the parser and the plane stores.
`include "bitplane_delta_frame_decoder_assert.svh"

module bdfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bdfd_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output bdfd_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    bdfd_pkg::t_cmd                 r_slot [bdfd_pkg::QUEUE_DEPTH];
    logic [bdfd_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [bdfd_pkg::QCNT_W-1:0]    r_count;

    assign o_ready = (r_count != bdfd_pkg::QCNT_W'(bdfd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `BDFD_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= bdfd_pkg::QCNT_W'(bdfd_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `BDFD_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `BDFD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not rise on push")

endmodule

// File: src/bdfd_back.sv
// Back end: four plane stores, pixel read pipeline and output register.
module bdfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bdfd_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    bdfd_out_if.source      o_out
);

    logic [bdfd_pkg::NUM_PLANES-1:0][7:0] r_rd;
    logic        r_s1_valid;
    logic        r_s1_kind;
    logic        r_s1_oor;
    logic        r_s1_marker;
    logic        r_s1_clip;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_pixels;
    logic        r_out_marker;
    logic        r_out_clip;

    logic out_free;
    logic s1_move;
    logic has_res;
    logic s1_load;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign has_res  = (i_cmd.res != bdfd_pkg::RES_NONE);
    // A plain write never waits on the result pipeline; reads already in flight hold their data.
    assign o_pop    = i_valid && (!has_res || !r_s1_valid || s1_move);
    assign s1_load  = o_pop && has_res;

    for (genvar p = 0; p < bdfd_pkg::NUM_PLANES; p++) begin : g_plane
        logic [7:0] mem [bdfd_pkg::PLANE_GROUPS];

        always_ff @(posedge i_clk) begin
            if (o_pop && i_cmd.wr_en && (i_cmd.plane == 2'(p))) begin
                mem[i_cmd.addr] <= i_cmd.data;
            end
            if (o_pop && (i_cmd.res == bdfd_pkg::RES_READ)) begin
                r_rd[p] <= mem[i_cmd.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind   <= (i_cmd.res == bdfd_pkg::RES_FINISH);
            r_s1_oor    <= i_cmd.oor;
            r_s1_marker <= i_cmd.marker;
            r_s1_clip   <= i_cmd.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_kind   <= r_s1_kind;
            r_out_pixels <= (r_s1_kind || r_s1_oor) ? 32'd0 : bdfd_pkg::f_chunky(r_rd);
            r_out_marker <= r_s1_marker;
            r_out_clip   <= r_s1_clip;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = r_out_kind;
    assign o_out.pixels          = r_out_pixels;
    assign o_out.ended_by_marker = r_out_marker;
    assign o_out.clipped         = r_out_clip;

endmodule

// File: src/bitplane_delta_frame_decoder.sv
// Top level of the bitplane delta frame decoder.
// Usage:
//   i_req carries one beat per frame byte (key or delta) or per pixel-group read.
//   o_res carries one beat per read (eight 4-bit chunky pixels) and one per
//   finished frame (end marker and clip flags, pixels zero).
//   A beat is taken whenever valid and ready are high at a clock edge.
// Throughput: one input beat per cycle, sustained while o_res.ready is high,
//   for any mix of bytes and reads; the plane stores take one write or one
//   four-plane read per cycle. A result passes the command queue register,
//   the registered plane-store read and the output register to reach o_res.
// Reads see every byte accepted before them, as stores are updated in order.
// Reset (i_rst_n low at a clock edge) idles the parser, clears the cursors,
//   counters and clip flag, and empties the queue and output register. The
//   picture stores are not cleared and hold no defined data until written.
// When the receiver holds o_res.ready low the output beat is held, the read
//   pipeline fills and the four-entry queue takes further beats; i_req.ready
//   falls once the queue is full and rises again as it drains.
module bitplane_delta_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdfd_in_if.sink     i_req,
    bdfd_out_if.source  o_res
);

    logic           cmd_valid;
    bdfd_pkg::t_cmd cmd;
    logic           q_ready;
    logic           q_valid;
    bdfd_pkg::t_cmd q_cmd;
    logic           q_pop;

    bdfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_req),
        .i_cmd_ready (q_ready),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    bdfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    bdfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_out   (o_res)
    );

endmodule

// File: bench/bitplane_delta_frame_decoder_test.sv
// Self-checking testbench for the bitplane delta frame decoder: preload, directed beats, random frames.
`timescale 1ns / 100ps

module bitplane_delta_frame_decoder_test;

    localparam int   STORE_BYTES  = bdfd_pkg::NUM_PLANES * bdfd_pkg::PLANE_GROUPS;
    localparam int   RANDOM_BEATS = 1710;
    localparam int   QUIET_LIMIT  = 2000;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   SCRIPT_ROWS  = 26;
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    typedef struct packed {
        bdfd_pkg::t_req req;
        logic           first;
        logic [7:0]     data;
        logic [12:0]    group;
    } t_beat;

    typedef struct packed {
        logic        kind;
        logic [31:0] pixels;
        logic        marker;
        logic        clip;
    } t_report;

    typedef struct packed {
        t_beat   beat;
        logic    typed;
        t_report want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdfd_in_if  req_if ();
    bdfd_out_if res_if ();

    bitplane_delta_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Picture held as four planes end to end, plus the frame parser state.
    logic [7:0]        picture [STORE_BYTES];
    bit                known   [STORE_BYTES];
    bdfd_pkg::t_phase  phase;
    logic [1:0]        plane_cur;
    logic [7:0]        row_cur;
    logic [13:0]       wr_group;
    logic [7:0]        run_left;
    logic [14:0]       key_count;
    logic              clip_flag;

    t_report     pending_reports [$];
    t_script_row script [SCRIPT_ROWS];
    bit          calm       = 1'b0;
    bit          failed     = 1'b0;
    int          beats_sent = 0;
    int          quiet      = 0;

    always #5 i_clk = ~i_clk;

    // A cursor code that moves the combined plane and row cursor on by the given steps.
    function automatic logic [7:0] skip_code(input int steps);
        return 8'(256 - steps);
    endfunction

    function automatic t_beat pack_beat(input bdfd_pkg::t_req req, input logic first,
                                        input logic [7:0] data, input logic [12:0] group);
        t_beat b;
        b.req   = req;
        b.first = first;
        b.data  = data;
        b.group = group;
        return b;
    endfunction

    // Reads go only to groups whose four planes hold known data, or past the picture end.
    function automatic logic [12:0] safe_group(input logic [12:0] g);
        if (g >= bdfd_pkg::PLANE_GROUPS) return g;
        for (int p = 0; p < bdfd_pkg::NUM_PLANES; p++) begin
            if (!known[p * bdfd_pkg::PLANE_GROUPS + g]) begin
                return 13'($urandom_range(bdfd_pkg::ROW_GROUPS - 1));
            end
        end
        return g;
    endfunction

    // Applies one accepted beat to the picture and parser; returns 1 when it yields a result.
    function automatic logic decode_beat(input t_beat b, output t_report r);
        int acc;
        int rows_now;
        int lin;
        r = '0;
        case (b.req)
            bdfd_pkg::REQ_KEY: begin
                if (b.first) begin
                    key_count = '0;
                    clip_flag = 1'b0;
                    phase     = bdfd_pkg::PH_IDLE;
                end
                if (key_count >= STORE_BYTES) return 1'b0;
                picture[key_count] = b.data;
                known[key_count]   = 1'b1;
                key_count = key_count + 1'b1;
                if (key_count != STORE_BYTES) return 1'b0;
                r.kind = KIND_FINISH;
                r.clip = clip_flag;
                return 1'b1;
            end
            bdfd_pkg::REQ_DELTA: begin
                if (b.first) begin
                    plane_cur = '0;
                    row_cur   = '0;
                    wr_group  = '0;
                    run_left  = '0;
                    clip_flag = 1'b0;
                    phase     = bdfd_pkg::PH_CODE;
                end
                case (phase)
                    bdfd_pkg::PH_CODE: begin
                        if (b.data == bdfd_pkg::CODE_END) begin
                            phase    = bdfd_pkg::PH_IDLE;
                            r.kind   = KIND_FINISH;
                            r.marker = 1'b1;
                            r.clip   = clip_flag;
                            return 1'b1;
                        end else if (b.data[7]) begin
                            acc       = plane_cur + (256 - b.data);
                            rows_now  = row_cur + (acc >> 2);
                            plane_cur = acc[1:0];
                            if (rows_now >= bdfd_pkg::ROWS) begin
                                row_cur = 8'(bdfd_pkg::ROWS);
                                phase   = bdfd_pkg::PH_IDLE;
                                r.kind  = KIND_FINISH;
                                r.clip  = clip_flag;
                                return 1'b1;
                            end
                            row_cur = 8'(rows_now);
                        end else begin
                            wr_group = 14'(b.data);
                            phase    = bdfd_pkg::PH_LEN;
                        end
                    end
                    bdfd_pkg::PH_LEN: begin
                        lin      = row_cur * bdfd_pkg::ROW_GROUPS + wr_group;
                        wr_group = (lin > bdfd_pkg::PLANE_GROUPS) ?
                                   14'(bdfd_pkg::PLANE_GROUPS) : 14'(lin);
                        run_left = b.data;
                        phase    = (b.data == 8'd0) ? bdfd_pkg::PH_CODE : bdfd_pkg::PH_DATA;
                    end
                    bdfd_pkg::PH_DATA: begin
                        if (wr_group < bdfd_pkg::PLANE_GROUPS) begin
                            picture[plane_cur * bdfd_pkg::PLANE_GROUPS + wr_group] = b.data;
                            known[plane_cur * bdfd_pkg::PLANE_GROUPS + wr_group]   = 1'b1;
                            wr_group = wr_group + 1'b1;
                        end else begin
                            clip_flag = 1'b1;
                        end
                        run_left = run_left - 1'b1;
                        if (run_left == 8'd0) phase = bdfd_pkg::PH_CODE;
                    end
                    default: ;
                endcase
                return 1'b0;
            end
            bdfd_pkg::REQ_READ: begin
                r.kind = KIND_READ;
                if (b.group < bdfd_pkg::PLANE_GROUPS) begin
                    for (int k = 0; k < 8; k++) begin
                        for (int p = 0; p < bdfd_pkg::NUM_PLANES; p++) begin
                            r.pixels[4*k + p] =
                                picture[p * bdfd_pkg::PLANE_GROUPS + b.group][7 - k];
                        end
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Drives one beat, waits for it to be taken and records what it should produce.
    task automatic offer_beat(input t_beat b, input logic typed = 1'b0,
                              input t_report want = '0);
        t_report got;
        if (b.req == bdfd_pkg::REQ_READ) b.group = safe_group(b.group);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 17) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= b.req;
        req_if.first_byte <= b.first;
        req_if.data_byte  <= b.data;
        req_if.read_group <= b.group;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        if (decode_beat(b, got) && !typed) pending_reports.push_back(got);
        if (typed) pending_reports.push_back(want);
        if (b.req != bdfd_pkg::REQ_NONE) beats_sent++;
    endtask

    task automatic offer_read();
        logic [12:0] g;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30) g = 13'($urandom_range(511));
        else if (pick < 40) g = 13'($urandom_range(8191, bdfd_pkg::PLANE_GROUPS));
        else g = 13'($urandom_range(bdfd_pkg::PLANE_GROUPS - 1));
        offer_beat(pack_beat(bdfd_pkg::REQ_READ, 1'b0, 8'($urandom), g));
    endtask

    // Fills the first row of every plane, then the last group of each plane.
    task automatic preload_picture();
        for (int p = 0; p < bdfd_pkg::NUM_PLANES; p++) begin
            if (p != 0) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, skip_code(1), 13'd0));
            end
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, p == 0, 8'h00, 13'd0));
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'(bdfd_pkg::ROW_GROUPS), 13'd0));
            repeat (bdfd_pkg::ROW_GROUPS) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'($urandom), 13'd0));
            end
        end
        offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, bdfd_pkg::CODE_END, 13'd0));
        for (int p = 0; p < bdfd_pkg::NUM_PLANES; p++) begin
            for (int n = 0; n < 6; n++) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, n == 0, skip_code(128), 13'd0));
            end
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, skip_code(28 + p), 13'd0));
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'(bdfd_pkg::ROW_GROUPS - 1),
                                 13'd0));
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'd1, 13'd0));
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'($urandom), 13'd0));
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, bdfd_pkg::CODE_END, 13'd0));
        end
    endtask

    task automatic offer_delta_frame();
        int         ops;
        int         len;
        int         pick;
        logic       first;
        logic       deep;
        logic [7:0] code;
        first = 1'b1;
        deep  = ($urandom_range(3) == 0);
        if (deep) begin
            // Drop towards the bottom of the picture so that runs can fall off its end.
            for (int n = 0; n < 6; n++) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, first, skip_code(128), 13'($urandom)));
                first = 1'b0;
            end
            offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, skip_code($urandom_range(1, 31)),
                                 13'($urandom)));
        end
        ops = $urandom_range(10);
        for (int n = 0; n < ops; n++) begin
            if (!first && phase == bdfd_pkg::PH_IDLE) break;
            if ($urandom_range(99) < 35) begin
                if (deep) begin
                    code = skip_code($urandom_range(1, 6));
                end else begin
                    do begin
                        code = 8'($urandom_range(128, 255));
                    end while (code == bdfd_pkg::CODE_END);
                end
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, first, code, 13'($urandom)));
                first = 1'b0;
            end else begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, first, 8'($urandom_range(127)),
                                     13'($urandom)));
                first = 1'b0;
                len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'(len), 13'($urandom)));
                for (int m = 0; m < len; m++) begin
                    if ($urandom_range(19) == 0) offer_read();
                    offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, 1'b0, 8'($urandom), 13'($urandom)));
                end
            end
        end
        if (first || phase != bdfd_pkg::PH_IDLE) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, first, bdfd_pkg::CODE_END,
                                     13'($urandom)));
            end else if (pick < 85) begin
                while (first || phase != bdfd_pkg::PH_IDLE) begin
                    offer_beat(pack_beat(bdfd_pkg::REQ_DELTA, first,
                                         skip_code($urandom_range(32, 128)), 13'($urandom)));
                    first = 1'b0;
                end
            end
            // Otherwise the frame is left unfinished and whatever follows cuts it off.
        end
    endtask

    always begin
        res_if.ready <= calm || ($urandom_range(99) >= 17);
        @(negedge i_clk);
    end

    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with none expected, got kind %0d pixels %h",
                         $time, res_if.result_kind, res_if.pixels);
                failed = 1'b1;
            end else begin
                want = pending_reports.pop_front();
                if (res_if.result_kind !== want.kind) begin
                    $display("%0t: result_kind expected %0d, got %0d",
                             $time, want.kind, res_if.result_kind);
                    failed = 1'b1;
                end
                if (res_if.pixels !== want.pixels) begin
                    $display("%0t: pixels expected %h, got %h", $time, want.pixels, res_if.pixels);
                    failed = 1'b1;
                end
                if (res_if.ended_by_marker !== want.marker) begin
                    $display("%0t: ended_by_marker expected %0d, got %0d",
                             $time, want.marker, res_if.ended_by_marker);
                    failed = 1'b1;
                end
                if (res_if.clipped !== want.clip) begin
                    $display("%0t: clipped expected %0d, got %0d", $time, want.clip, res_if.clipped);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("bitplane_delta_frame_decoder test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int target;
        int pick;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= bdfd_pkg::REQ_NONE;
        req_if.first_byte <= 1'b0;
        req_if.data_byte  <= 8'h00;
        req_if.read_group <= 13'd0;
        i_rst_n           <= 1'b0;
        phase     = bdfd_pkg::PH_IDLE;
        plane_cur = '0;
        row_cur   = '0;
        wr_group  = '0;
        run_left  = '0;
        key_count = '0;
        clip_flag = 1'b0;

        // The third and fourth rows are beats the decoder must ignore; the fifth is a stray
        // key byte that lands on the first group of plane 0.
        script = '{
            '{'{bdfd_pkg::REQ_READ,  1'b0, 8'h00, 13'd8000}, 1'b1,
              '{KIND_READ, 32'h0, 1'b0, 1'b0}},
            '{'{bdfd_pkg::REQ_READ,  1'b0, 8'hFF, 13'h1FFF}, 1'b1,
              '{KIND_READ, 32'h0, 1'b0, 1'b0}},
            '{'{bdfd_pkg::REQ_NONE,  1'b1, bdfd_pkg::CODE_END, 13'd5}, 1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h05,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_KEY,   1'b0, 8'hFF,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b1, bdfd_pkg::CODE_END, 13'd0}, 1'b1,
              '{KIND_FINISH, 32'h0, 1'b1, 1'b0}},
            '{'{bdfd_pkg::REQ_DELTA, 1'b1, skip_code(1),   13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h03,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h02,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h00,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'hFF,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h7F,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h00,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(128), 13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(28),  13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h7F,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'h01,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, 8'hA5,          13'd0},    1'b0, '0},
            '{'{bdfd_pkg::REQ_DELTA, 1'b0, skip_code(4),   13'd0},    1'b1,
              '{KIND_FINISH, 32'h0, 1'b0, 1'b1}},
            '{'{bdfd_pkg::REQ_READ,  1'b0, 8'h00,          13'd4},    1'b0, '0},
            '{'{bdfd_pkg::REQ_READ,  1'b0, 8'h00,          13'd7999}, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Known data in the first row and the last group before anything reads them.
        preload_picture();

        foreach (script[i]) offer_beat(script[i].beat, script[i].typed, script[i].want);

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            calm = (target - beats_sent < 1200) && (target - beats_sent >= 850);
            pick = $urandom_range(99);
            if (pick < 50) begin
                offer_delta_frame();
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 6)) offer_read();
            end else if (pick < 88) begin
                offer_beat(pack_beat(bdfd_pkg::REQ_KEY, 1'b1, 8'($urandom), 13'($urandom)));
                repeat ($urandom_range(12)) begin
                    offer_beat(pack_beat(bdfd_pkg::REQ_KEY, 1'b0, 8'($urandom), 13'($urandom)));
                end
            end else begin
                // Stray beat of any type, the unused request code included.
                offer_beat(pack_beat(bdfd_pkg::t_req'($urandom_range(3)), 1'($urandom),
                                     8'($urandom), 13'($urandom)));
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && pending_reports.size() == 0) begin
            $display("bitplane_delta_frame_decoder test passed");
        end else begin
            $display("bitplane_delta_frame_decoder test failed");
        end
        $finish;
    end

endmodule
